/* rtl/cpu_register_and_flag_unit_core_assert.svh */
// assertion macros shared by the register and flag unit
`ifndef CPU_REGISTER_AND_FLAG_UNIT_CORE_ASSERT_SVH
`define CPU_REGISTER_AND_FLAG_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CRU_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cru implication check failed");

// next-cycle implication
`define CRU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cru next-cycle check failed");

`else

`define CRU_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define CRU_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/cru_pkg.sv */
`timescale 1ns / 1ps

package cru_pkg;

   // operation codes
   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_ADC     = 3'd2;
   localparam logic [2:0] OP_SBC     = 3'd3;
   localparam logic [2:0] OP_CMP     = 3'd4;
   localparam logic [2:0] OP_STACK   = 3'd5;
   localparam logic [2:0] OP_PACK    = 3'd6;
   localparam logic [2:0] OP_UNPACK  = 3'd7;

   // register selects
   localparam logic [2:0] SEL_ACC    = 3'd0;
   localparam logic [2:0] SEL_X      = 3'd1;
   localparam logic [2:0] SEL_Y      = 3'd2;
   localparam logic [2:0] SEL_S      = 3'd3;
   localparam logic [2:0] SEL_D      = 3'd4;
   localparam logic [2:0] SEL_PB     = 3'd5;
   localparam logic [2:0] SEL_DB     = 3'd6;

   // status bit positions, NVMXDIZC
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_M = 5;
   localparam int FLAG_X = 4;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] MX_MASK    = 8'h30;
   localparam logic [7:0] STACK_PAGE = 8'h01;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  register_select;
      logic [15:0] write_value;
      logic        force_wide;
      logic [7:0]  operand_a;
      logic [7:0]  operand_b;
      logic        upper_half;
      logic        stack_down;
   } cru_req_type;

   typedef struct packed {
      logic [15:0] data_out;
      logic [7:0]  flags_out;
   } cru_rsp_type;

   typedef struct packed {
      logic [7:0]  acc_low;
      logic [7:0]  acc_high;
      logic [15:0] index_x;
      logic [15:0] index_y;
      logic [15:0] stack_pointer;
      logic [15:0] direct_page;
      logic [7:0]  program_bank;
      logic [7:0]  data_bank;
      logic [7:0]  status_bits;
      logic        low_zero_stash;
   } cru_state_type;

   localparam cru_state_type STATE_RESET = '{
      acc_low:        8'h00,
      acc_high:       8'h00,
      index_x:        16'h0000,
      index_y:        16'h0000,
      stack_pointer:  16'h01FF,
      direct_page:    16'h0000,
      program_bank:   8'h00,
      data_bank:      8'h00,
      status_bits:    MX_MASK,
      low_zero_stash: 1'b0
   };

endpackage

/* rtl/cru_alu.sv */
`timescale 1ns / 1ps

module cru_alu (
   input  logic                   emulation,
   input  cru_pkg::cru_state_type cur_state,
   input  cru_pkg::cru_req_type   req,
   output cru_pkg::cru_state_type next_state,
   output cru_pkg::cru_rsp_type   rsp
);
   import cru_pkg::*;

   function automatic cru_state_type nz_byte(input cru_state_type s, input logic chain,
                                             input logic [7:0] v);
      cru_state_type r;
      logic          z;
      r = s;
      z = (v == 8'h00);
      r.status_bits[FLAG_N] = v[7];
      if (chain) begin
         r.status_bits[FLAG_Z] = z & s.low_zero_stash;
      end else begin
         r.low_zero_stash      = z;
         r.status_bits[FLAG_Z] = z;
      end
      return r;
   endfunction

   function automatic cru_state_type nz_word(input cru_state_type s, input logic [15:0] v);
      cru_state_type r;
      r = s;
      r.status_bits[FLAG_N] = v[15];
      r.status_bits[FLAG_Z] = (v == 16'h0000);
      return r;
   endfunction

   logic        m_wide;
   logic        x_wide;
   logic        idx_wide;
   logic [7:0]  wr_lo;
   logic [7:0]  wr_hi;
   logic [7:0]  addend;
   logic [8:0]  sum;
   logic [8:0]  diff;
   logic [15:0] sp_step;
   logic [15:0] rd_value;
   logic [7:0]  unpack_bits;

   assign m_wide   = !emulation && !cur_state.status_bits[FLAG_M];
   assign x_wide   = !emulation && !cur_state.status_bits[FLAG_X];
   assign idx_wide = req.force_wide || x_wide;
   assign wr_lo    = req.write_value[7:0];
   assign wr_hi    = req.write_value[15:8];

   // adc and sbc share one adder, sbc inverts the second operand
   assign addend = (req.req_type == OP_SBC) ? ~req.operand_b : req.operand_b;
   assign sum    = {1'b0, req.operand_a} + {1'b0, addend}
                 + {8'h00, cur_state.status_bits[FLAG_C]};
   assign diff   = {1'b0, req.operand_a} + {1'b0, ~req.operand_b} + 9'd1;

   assign sp_step = req.stack_down ? (cur_state.stack_pointer - 16'd1)
                                   : (cur_state.stack_pointer + 16'd1);

   assign unpack_bits = emulation
                      ? ((req.operand_b & ~MX_MASK) | (cur_state.status_bits & MX_MASK))
                      : req.operand_b;

   always_comb begin
      unique case (req.register_select)
         SEL_ACC: rd_value = {cur_state.acc_high, cur_state.acc_low};
         SEL_X:   rd_value = idx_wide ? cur_state.index_x : {8'h00, cur_state.index_x[7:0]};
         SEL_Y:   rd_value = idx_wide ? cur_state.index_y : {8'h00, cur_state.index_y[7:0]};
         SEL_S:   rd_value = cur_state.stack_pointer;
         SEL_D:   rd_value = cur_state.direct_page;
         SEL_PB:  rd_value = {8'h00, cur_state.program_bank};
         SEL_DB:  rd_value = {8'h00, cur_state.data_bank};
         default: rd_value = 16'h0000;
      endcase
   end

   always_comb begin
      next_state   = cur_state;
      rsp.data_out = 16'h0000;
      unique case (req.req_type)
         OP_READ: begin
            rsp.data_out = rd_value;
         end
         OP_WRITE: begin
            unique case (req.register_select)
               SEL_ACC: begin
                  next_state.acc_low = wr_lo;
                  if (req.force_wide) begin
                     next_state.acc_high = wr_hi;
                     next_state = nz_word(next_state, req.write_value);
                  end else begin
                     next_state = nz_byte(next_state, req.upper_half, wr_lo);
                     // second byte always chains onto the first
                     if (m_wide) begin
                        next_state.acc_high = wr_hi;
                        next_state = nz_byte(next_state, 1'b1, wr_hi);
                     end
                  end
               end
               SEL_X: begin
                  if (idx_wide) begin
                     next_state.index_x = req.write_value;
                     next_state = nz_word(next_state, req.write_value);
                  end else begin
                     next_state.index_x = {cur_state.index_x[15:8], wr_lo};
                     next_state = nz_byte(next_state, req.upper_half, wr_lo);
                  end
               end
               SEL_Y: begin
                  if (idx_wide) begin
                     next_state.index_y = req.write_value;
                     next_state = nz_word(next_state, req.write_value);
                  end else begin
                     next_state.index_y = {cur_state.index_y[15:8], wr_lo};
                     next_state = nz_byte(next_state, req.upper_half, wr_lo);
                  end
               end
               SEL_S: begin
                  next_state.stack_pointer = emulation ? {STACK_PAGE, wr_lo}
                                                       : req.write_value;
               end
               SEL_D: begin
                  next_state.direct_page = req.write_value;
                  next_state = nz_word(next_state, req.write_value);
               end
               SEL_PB: begin
                  next_state.program_bank = wr_lo;
                  next_state = nz_byte(next_state, req.upper_half, wr_lo);
               end
               SEL_DB: begin
                  next_state.data_bank = wr_lo;
                  next_state = nz_byte(next_state, req.upper_half, wr_lo);
               end
               default: begin
               end
            endcase
         end
         OP_ADC, OP_SBC: begin
            next_state.status_bits[FLAG_C] = sum[8];
            next_state.status_bits[FLAG_V] =
               ((req.operand_a[7] ^ sum[7]) & (addend[7] ^ sum[7]));
            rsp.data_out = {8'h00, sum[7:0]};
         end
         OP_CMP: begin
            next_state.status_bits[FLAG_C] = diff[8];
            next_state = nz_byte(next_state, req.upper_half, diff[7:0]);
            rsp.data_out = {8'h00, diff[7:0]};
         end
         OP_STACK: begin
            next_state.stack_pointer = emulation ? {STACK_PAGE, sp_step[7:0]} : sp_step;
            rsp.data_out = next_state.stack_pointer;
         end
         OP_PACK: begin
            rsp.data_out = {8'h00, (emulation ? (cur_state.status_bits | MX_MASK)
                                              : cur_state.status_bits)};
         end
         OP_UNPACK: begin
            next_state.status_bits = unpack_bits;
         end
         default: begin
         end
      endcase
      rsp.flags_out = emulation ? (next_state.status_bits | MX_MASK)
                                : next_state.status_bits;
   end

endmodule

/* rtl/cru_regfile.sv */
`timescale 1ns / 1ps

module cru_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_value,
   input  logic                   update,
   input  cru_pkg::cru_state_type next_state,
   output cru_pkg::cru_state_type cur_state,
   output logic                   emulation
);
   import cru_pkg::*;

   cru_state_type state_ff;
   cru_state_type state_in;
   logic          emulation_ff;
   logic          emulation_in;

   always_comb begin
      state_in     = state_ff;
      emulation_in = emulation_ff;
      priority if (csr_write) begin
         emulation_in = csr_value;
         // entering emulation pins the stack page and sets m and x
         if (csr_value) begin
            state_in.stack_pointer = {STACK_PAGE, state_ff.stack_pointer[7:0]};
            state_in.status_bits   = state_ff.status_bits | MX_MASK;
         end
      end else if (update) begin
         state_in = next_state;
      end else begin
         // idle cycle, state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         emulation_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         emulation_ff <= emulation_in;
      end
   end

   assign cur_state = state_ff;
   assign emulation = emulation_ff;

endmodule

/* rtl/cpu_register_and_flag_unit_core.sv */
`timescale 1ns / 1ps
`include "cpu_register_and_flag_unit_core_assert.svh"
// register file and status flag unit of a 16-bit processor core
// req channel: one micro-operation per transfer (read, write, adc, sbc,
//   compare, stack step, flag pack, flag unpack) as a cru_req_type struct
// rsp channel: exactly one result per request, data_out plus the packed
//   status byte after the operation, in request order
// csr channel: single-bit emulation mode write, always ready; write it only
//   while no request is in flight
// result path: a transferred request is held in the input register, then
//   in the result register, from which it shows on rsp
// throughput: one request per cycle unless rsp stalls; the execute stage
//   is a single pass of byte adder, register mux and flag logic between the
//   input register and the result register, and architectural state updates
//   at that same edge, so a following request sees it with no bubble
// reset: synchronous; registers clear, stack pointer 0x01ff, m and x set,
//   emulation mode on, both pipeline stages empty
// stall: a held result keeps the input stage loaded; req_ready drops only
//   when both stages are full and rsp_ready is low
module cpu_register_and_flag_unit_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cru_pkg::cru_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cru_pkg::cru_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_emulation_mode
);
   import cru_pkg::*;

   // input stage
   logic          in_valid_ff;
   logic          in_valid_in;
   cru_req_type   in_req_ff;

   // result stage
   logic          out_valid_ff;
   logic          out_valid_in;
   cru_rsp_type   out_rsp_ff;

   // execute stage wiring
   cru_state_type cur_state;
   cru_state_type next_state;
   cru_rsp_type   exec_rsp;
   logic          emulation;
   logic          advance;
   logic          req_fire;
   logic          csr_fire;

   // the input stage moves on when the result stage is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid && csr_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   cru_alu u_alu (
      .emulation  (emulation),
      .cur_state  (cur_state),
      .req        (in_req_ff),
      .next_state (next_state),
      .rsp        (exec_rsp)
   );

   // architectural state commits on the same edge the result is captured, unless a csr write takes priority
   cru_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_fire),
      .csr_value  (csr_emulation_mode),
      .update     (advance),
      .next_state (next_state),
      .cur_state  (cur_state),
      .emulation  (emulation)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // emulation keeps the stack in page one
   `CRU_ASSERT_IMPLY(a_emu_stack_page, clock, reset, emulation, cur_state.stack_pointer[15:8] == STACK_PAGE)
   // emulation keeps m and x set in the stored status
   `CRU_ASSERT_IMPLY(a_emu_mx_set, clock, reset, emulation, (cur_state.status_bits & MX_MASK) == MX_MASK)
   // an executed request always lands in the result stage
   `CRU_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)
   // a blocked request is never dropped from the input stage
   `CRU_ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
